>>> sv/dqes_pkg.sv
// ----------------------------------------------------------------------------
// dqes_pkg
// Shared types, codes and sizes for the dual quadrature encoder speed unit.
// ----------------------------------------------------------------------------
package dqes_pkg;

  // Datapath sizes
  localparam int CNT_W      = 32;   // pulse count and pulse rate
  localparam int RPS_W      = 48;   // revolution rate, signed Q16
  localparam int Q_FRAC     = 16;   // fractional bits of the revolution rate
  localparam int CFG_W      = 16;   // widest configuration register
  localparam int CFG_ADDR_W = 1;    // configuration register index

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  // Serial divider: quotient bits retired per cycle and cycles per divide
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = RPS_W / DIV_BITS;
  localparam int DIV_CNT_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSES_PER_REV = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_S  = 1'd1;

  localparam logic [CFG_W-1:0] PPR_RESET = 16'd1;
  localparam logic [CFG_W-1:0] SPS_RESET = 16'd100;

  // Largest magnitude the 31-bit pulse rate magnitude can show
  localparam logic [CNT_W-2:0] PPS_ABS_MAX = 31'h7fff_ffff;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // Motor codes
  localparam logic [1:0] MOTOR_LEFT  = 2'd0;
  localparam logic [1:0] MOTOR_RIGHT = 2'd1;
  localparam logic [1:0] MOTOR_BOTH  = 2'd2;
  localparam logic [1:0] MOTOR_NONE  = 2'd3;

  // Net count change of one motor from one edge transaction: -2 .. +2
  typedef logic signed [2:0] step_t;

  // Classified operation handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] motor;
    step_t      step_l;
    step_t      step_r;
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RESP
  } exec_st_t;

  // Net step of one encoder: first pin counts up when the levels differ,
  // second pin counts the other way
  function automatic step_t pin_step(input logic first_edge,
                                     input logic second_edge,
                                     input logic differ);
    step_t s;
    s = 3'sd0;
    if (first_edge) begin
      s = differ ? (s + 3'sd1) : (s - 3'sd1);
    end
    if (second_edge) begin
      s = differ ? (s - 3'sd1) : (s + 3'sd1);
    end
    return s;
  endfunction

endpackage

>>> sv/dqes_front.sv
// ----------------------------------------------------------------------------
// dqes_front
// Accepts input transactions and classifies them into queue operations.
// ----------------------------------------------------------------------------
module dqes_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [1:0]          in_motor,
  input  logic [3:0]          in_edge_mask,
  input  logic [3:0]          in_pin_levels,
  input  logic                fifo_full,
  output logic                push,
  output dqes_pkg::op_t       push_op
);

  logic differ_l;
  logic differ_r;
  logic is_edge;

  // Accept whenever the queue has room
  assign in_stall = fifo_full;
  assign push     = in_valid & ~fifo_full;

  // Edge classification; pins are ignored on every other command
  assign is_edge  = (dqes_pkg::cmd_t'(in_cmd) == dqes_pkg::CMD_EDGE);
  assign differ_l = in_pin_levels[0] ^ in_pin_levels[1];
  assign differ_r = in_pin_levels[2] ^ in_pin_levels[3];

  always_comb begin
    push_op.cmd   = dqes_pkg::cmd_t'(in_cmd);
    push_op.motor = in_motor;
    if (is_edge) begin
      push_op.step_l = dqes_pkg::pin_step(in_edge_mask[0], in_edge_mask[1], differ_l);
      push_op.step_r = dqes_pkg::pin_step(in_edge_mask[2], in_edge_mask[3], differ_r);
    end else begin
      push_op.step_l = 3'sd0;
      push_op.step_r = 3'sd0;
    end
  end

endmodule

>>> sv/dqes_fifo.sv
// ----------------------------------------------------------------------------
// dqes_fifo
// Short operation queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module dqes_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dqes_pkg::op_t push_op,
  input  logic          pop,
  output dqes_pkg::op_t pop_op,
  output logic          full,
  output logic          not_empty
);

  dqes_pkg::op_t                    mem_r [dqes_pkg::FIFO_DEPTH];
  logic [dqes_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [dqes_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [dqes_pkg::FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == dqes_pkg::FIFO_CNT_W'(dqes_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_op    = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> sv/dqes_back.sv
// ----------------------------------------------------------------------------
// dqes_back
// Executes queued operations: count updates, clears, speed sampling with a
// shared multiplier and a 2-bit-per-cycle divider, and the result register.
// ----------------------------------------------------------------------------
module dqes_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 op_valid,
  input  dqes_pkg::op_t                        op,
  output logic                                 pop,
  input  logic [dqes_pkg::CFG_W-1:0]           pulses_per_rev,
  input  logic [dqes_pkg::CFG_W-1:0]           samples_per_s,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dqes_pkg::CNT_W-1:0]    out_position_count,
  output logic signed [dqes_pkg::CNT_W-1:0]    out_pulse_rate,
  output logic [dqes_pkg::CNT_W-2:0]           out_pulse_rate_abs,
  output logic signed [dqes_pkg::RPS_W-1:0]    out_rev_rate_q16,
  output logic [dqes_pkg::RPS_W-1:0]           out_rev_rate_abs_q16
);

  localparam int CNT_W = dqes_pkg::CNT_W;
  localparam int RPS_W = dqes_pkg::RPS_W;
  localparam int CFG_W = dqes_pkg::CFG_W;
  localparam int PROD_W = CNT_W + CFG_W;

  // Per-motor state
  logic [CNT_W-1:0] count_r [2];
  logic [CNT_W-1:0] prev_r  [2];
  logic [CNT_W-1:0] pps_r   [2];
  logic [RPS_W-1:0] rps_r   [2];

  dqes_pkg::exec_st_t state_r, state_nxt;
  dqes_pkg::op_t      cur_r;
  logic               lane_r;

  // Divider registers
  logic [RPS_W-1:0]               dvd_r;
  logic [CFG_W-1:0]               rem_r;
  logic [CFG_W-1:0]               dvs_r;
  logic                           neg_r;
  logic [dqes_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic out_valid_r, out_valid_nxt;
  logic signed [CNT_W-1:0] pos_out_r;
  logic signed [CNT_W-1:0] pps_out_r;
  logic [CNT_W-2:0]        pps_abs_out_r;
  logic signed [RPS_W-1:0] rps_out_r;
  logic [RPS_W-1:0]        rps_abs_out_r;

  logic             load_out;
  logic             div_last;
  logic [CNT_W-1:0] lane_count;
  logic [CNT_W-1:0] lane_prev;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0] pps_new;
  logic [CNT_W-1:0] pps_mag;
  logic [RPS_W-1:0] dvd_step;
  logic [CFG_W-1:0] rem_step;
  logic [CFG_W:0]   trial;
  logic [RPS_W-1:0] rps_new;

  // Reported values
  logic             rep_on;
  logic [CNT_W-1:0] rep_count;
  logic [CNT_W-1:0] rep_pps;
  logic [RPS_W-1:0] rep_rps;
  logic [CNT_W-1:0] rep_pps_mag;

  // Sequencer: next state and control
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      dqes_pkg::ST_IDLE: begin
        if (op_valid) begin
          pop       = 1'b1;
          state_nxt = (op.cmd == dqes_pkg::CMD_TICK) ? dqes_pkg::ST_MUL : dqes_pkg::ST_RESP;
        end
      end
      dqes_pkg::ST_MUL: begin
        state_nxt = dqes_pkg::ST_DIV;
      end
      dqes_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = lane_r ? dqes_pkg::ST_RESP : dqes_pkg::ST_MUL;
        end
      end
      dqes_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = dqes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dqes_pkg::ST_IDLE;
    endcase
  end

  assign div_last = (div_cnt_r == dqes_pkg::DIV_CNT_W'(dqes_pkg::DIV_STEPS - 1));

  // Pulse rate of the motor being sampled
  assign lane_count = lane_r ? count_r[1] : count_r[0];
  assign lane_prev  = lane_r ? prev_r[1]  : prev_r[0];
  assign prod       = (lane_count - lane_prev) * samples_per_s;
  assign pps_new    = prod[CNT_W-1:0];
  assign pps_mag    = pps_new[CNT_W-1] ? (~pps_new + 1'b1) : pps_new;

  // Two restoring division steps per cycle; quotient bits enter dvd_r from below
  always_comb begin
    dvd_step = dvd_r;
    rem_step = rem_r;
    trial    = '0;
    for (int i = 0; i < dqes_pkg::DIV_BITS; i++) begin
      trial    = {rem_step, dvd_step[RPS_W-1]};
      dvd_step = {dvd_step[RPS_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial       = trial - {1'b0, dvs_r};
        dvd_step[0] = 1'b1;
      end
      rem_step = trial[CFG_W-1:0];
    end
  end

  assign rps_new = neg_r ? (~dvd_step + 1'b1) : dvd_step;

  // Result selection for the addressed motor
  assign rep_on      = ~cur_r.motor[1];
  assign rep_count   = cur_r.motor[0] ? count_r[1] : count_r[0];
  assign rep_pps     = cur_r.motor[0] ? pps_r[1]   : pps_r[0];
  assign rep_rps     = cur_r.motor[0] ? rps_r[1]   : rps_r[0];
  assign rep_pps_mag = rep_pps[CNT_W-1] ? (~rep_pps + 1'b1) : rep_pps;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqes_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Motor state: edges, clears and sampling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < 2; m++) begin
        count_r[m] <= '0;
        prev_r[m]  <= '0;
        pps_r[m]   <= '0;
        rps_r[m]   <= '0;
      end
    end else if (pop) begin
      if (op.cmd == dqes_pkg::CMD_EDGE) begin
        count_r[0] <= count_r[0] + {{(CNT_W-3){op.step_l[2]}}, op.step_l};
        count_r[1] <= count_r[1] + {{(CNT_W-3){op.step_r[2]}}, op.step_r};
      end else if (op.cmd == dqes_pkg::CMD_RESET) begin
        if (op.motor == dqes_pkg::MOTOR_LEFT || op.motor == dqes_pkg::MOTOR_BOTH) begin
          count_r[0] <= '0;
          prev_r[0]  <= '0;
          pps_r[0]   <= '0;
          rps_r[0]   <= '0;
        end
        if (op.motor == dqes_pkg::MOTOR_RIGHT || op.motor == dqes_pkg::MOTOR_BOTH) begin
          count_r[1] <= '0;
          prev_r[1]  <= '0;
          pps_r[1]   <= '0;
          rps_r[1]   <= '0;
        end
      end
    end else if (state_r == dqes_pkg::ST_MUL) begin
      pps_r[lane_r]  <= pps_new;
      prev_r[lane_r] <= lane_count;
    end else if (state_r == dqes_pkg::ST_DIV && div_last) begin
      rps_r[lane_r] <= rps_new;
    end
  end

  // Sampling sequence and divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= op;
      lane_r <= 1'b0;
    end else if (state_r == dqes_pkg::ST_MUL) begin
      neg_r     <= pps_new[CNT_W-1];
      dvd_r     <= {pps_mag, {dqes_pkg::Q_FRAC{1'b0}}};
      rem_r     <= '0;
      dvs_r     <= (pulses_per_rev == '0) ? CFG_W'(1) : pulses_per_rev;
      div_cnt_r <= '0;
    end else if (state_r == dqes_pkg::ST_DIV) begin
      dvd_r     <= dvd_step;
      rem_r     <= rem_step;
      div_cnt_r <= div_cnt_r + 1'b1;
      if (div_last) begin
        lane_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (rep_on) begin
        pos_out_r     <= rep_count;
        pps_out_r     <= rep_pps;
        pps_abs_out_r <= rep_pps_mag[CNT_W-1] ? dqes_pkg::PPS_ABS_MAX
                                              : rep_pps_mag[CNT_W-2:0];
        rps_out_r     <= rep_rps;
        rps_abs_out_r <= rep_rps[RPS_W-1] ? (~rep_rps + 1'b1) : rep_rps;
      end else begin
        pos_out_r     <= '0;
        pps_out_r     <= '0;
        pps_abs_out_r <= '0;
        rps_out_r     <= '0;
        rps_abs_out_r <= '0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_position_count   = pos_out_r;
  assign out_pulse_rate       = pps_out_r;
  assign out_pulse_rate_abs   = pps_abs_out_r;
  assign out_rev_rate_q16     = rps_out_r;
  assign out_rev_rate_abs_q16 = rps_abs_out_r;

endmodule

>>> sv/dual_quadrature_encoder_speed_unit.sv
// ----------------------------------------------------------------------------
// dual_quadrature_encoder_speed_unit
// Position and speed tracker for a left and a right quadrature encoder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   pin edge, speed sample tick, motor reset or plain query. Every input
//   transaction yields exactly one result transaction on the out_ channel
//   (out_valid / out_stall) with the addressed motor's count and rates;
//   motors 2 and 3 report all zeros.
//   Configuration (cfg_we / cfg_addr / cfg_wdata) sets pulses per revolution
//   and samples per second; write only while the unit is idle.
// Timing:
//   A two-entry queue separates the input side from the execution sequencer.
//   Edge, reset and query transactions pass through the queue and the
//   sequencer's response state into the result register. A tick runs, per
//   motor in turn, one multiply state and then the serial divider (2
//   quotient bits per cycle) on the shared datapath. The sequencer takes a
//   new command only after the previous one's result is loaded.
// Reset / stall:
//   rst_n (synchronous, active low) clears counts, rates and the queue and
//   restores pulses_per_rev = 1, samples_per_second = 100. While out_stall is
//   high the result holds; the queue keeps taking input until it fills, then
//   in_stall rises.
// ----------------------------------------------------------------------------
module dual_quadrature_encoder_speed_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_cmd,
  input  logic [1:0]                           in_motor,
  input  logic [3:0]                           in_edge_mask,
  input  logic [3:0]                           in_pin_levels,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dqes_pkg::CNT_W-1:0]    out_position_count,
  output logic signed [dqes_pkg::CNT_W-1:0]    out_pulse_rate,
  output logic [dqes_pkg::CNT_W-2:0]           out_pulse_rate_abs,
  output logic signed [dqes_pkg::RPS_W-1:0]    out_rev_rate_q16,
  output logic [dqes_pkg::RPS_W-1:0]           out_rev_rate_abs_q16,
  input  logic                                 cfg_we,
  input  logic [dqes_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [dqes_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [dqes_pkg::CFG_W-1:0] ppr_r;
  logic [dqes_pkg::CFG_W-1:0] sps_r;

  logic          push;
  dqes_pkg::op_t push_op;
  logic          pop;
  dqes_pkg::op_t pop_op;
  logic          fifo_full;
  logic          fifo_not_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= dqes_pkg::PPR_RESET;
      sps_r <= dqes_pkg::SPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dqes_pkg::CFG_PULSES_PER_REV: ppr_r <= cfg_wdata;
        dqes_pkg::CFG_SAMPLES_PER_S:  sps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dqes_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_motor      (in_motor),
    .in_edge_mask  (in_edge_mask),
    .in_pin_levels (in_pin_levels),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_op       (push_op)
  );

  dqes_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .pop_op    (pop_op),
    .full      (fifo_full),
    .not_empty (fifo_not_empty)
  );

  dqes_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op_valid             (fifo_not_empty),
    .op                   (pop_op),
    .pop                  (pop),
    .pulses_per_rev       (ppr_r),
    .samples_per_s        (sps_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_position_count   (out_position_count),
    .out_pulse_rate       (out_pulse_rate),
    .out_pulse_rate_abs   (out_pulse_rate_abs),
    .out_rev_rate_q16     (out_rev_rate_q16),
    .out_rev_rate_abs_q16 (out_rev_rate_abs_q16)
  );

endmodule

>>> sv/dqes_checker.sv
// ----------------------------------------------------------------------------
// dqes_checker
// Port-level checks for the dual quadrature encoder speed unit.
// ----------------------------------------------------------------------------
module dqes_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_stall,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [dqes_pkg::CNT_W-1:0]    out_position_count,
  input  logic signed [dqes_pkg::CNT_W-1:0]    out_pulse_rate,
  input  logic [dqes_pkg::CNT_W-2:0]           out_pulse_rate_abs,
  input  logic signed [dqes_pkg::RPS_W-1:0]    out_rev_rate_q16,
  input  logic [dqes_pkg::RPS_W-1:0]           out_rev_rate_abs_q16
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position_count) &&
      $stable(out_pulse_rate) && $stable(out_rev_rate_q16))
    else $error("result changed while stalled");

  // Pulse rate magnitude matches the signed rate, saturated
  a_pps_abs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pulse_rate_abs ==
      (out_pulse_rate[31] ?
        ((out_pulse_rate == 32'sh8000_0000) ? 31'h7fff_ffff : 31'(-out_pulse_rate)) :
        31'(out_pulse_rate)))
    else $error("pulse rate magnitude mismatch");

  // Revolution rate magnitude matches the signed rate
  a_rps_abs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rev_rate_abs_q16 ==
      (out_rev_rate_q16[47] ? 48'(-out_rev_rate_q16) : 48'(out_rev_rate_q16)))
    else $error("revolution rate magnitude mismatch");

  // Reset empties the queue and the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not empty after reset");

endmodule

bind dual_quadrature_encoder_speed_unit dqes_checker u_dqes_checker (.*);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual quadrature encoder speed unit. A clocked
// driver feeds queued command transactions with random gaps, a clocked monitor
// stalls at random and checks every result against an in-bench tracker.
// Covers directed corner commands, several rate settings (including the
// extremes and a zero divisor) and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CNT_W        = dqes_pkg::CNT_W;
  localparam int RPS_W        = dqes_pkg::RPS_W;
  localparam int CFG_W        = dqes_pkg::CFG_W;
  localparam int CFG_ADDR_W   = dqes_pkg::CFG_ADDR_W;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int MAX_WAIT     = 19;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 220;
  localparam int RATE_PHASES  = 7;
  localparam int MAX_REPORTS  = 50;

  // One command transaction plus the idle cycles the driver waits before it
  typedef struct {
    dqes_pkg::cmd_t cmd;
    logic [1:0]     motor;
    logic [3:0]     edge_mask;
    logic [3:0]     pin_levels;
    int unsigned    gap;
  } enc_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [CNT_W-1:0] position_count;
    logic signed [CNT_W-1:0] pulse_rate;
    logic [CNT_W-2:0]        pulse_rate_abs;
    logic signed [RPS_W-1:0] rev_rate_q16;
    logic [RPS_W-1:0]        rev_rate_abs_q16;
  } enc_report_t;

  // Clock and DUT inputs, all known from time zero
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic [1:0]            in_cmd        = 2'd0;
  logic [1:0]            in_motor      = 2'd0;
  logic [3:0]            in_edge_mask  = 4'd0;
  logic [3:0]            in_pin_levels = 4'd0;
  logic                  out_stall     = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_W-1:0]      cfg_wdata     = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic signed [CNT_W-1:0] out_position_count;
  logic signed [CNT_W-1:0] out_pulse_rate;
  logic [CNT_W-2:0]        out_pulse_rate_abs;
  logic signed [RPS_W-1:0] out_rev_rate_q16;
  logic [RPS_W-1:0]        out_rev_rate_abs_q16;

  always #(HALF_PERIOD) clk = ~clk;

  dual_quadrature_encoder_speed_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_motor             (in_motor),
    .in_edge_mask         (in_edge_mask),
    .in_pin_levels        (in_pin_levels),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_position_count   (out_position_count),
    .out_pulse_rate       (out_pulse_rate),
    .out_pulse_rate_abs   (out_pulse_rate_abs),
    .out_rev_rate_q16     (out_rev_rate_q16),
    .out_rev_rate_abs_q16 (out_rev_rate_abs_q16),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

  // Tracker state: counts, last sampled counts and rates per motor
  logic [CFG_W-1:0]        trk_ppr = dqes_pkg::PPR_RESET;
  logic [CFG_W-1:0]        trk_sps = dqes_pkg::SPS_RESET;
  logic [CNT_W-1:0]        trk_count [2];
  logic [CNT_W-1:0]        trk_last  [2];
  logic [CNT_W-1:0]        trk_pps   [2];
  logic signed [RPS_W-1:0] trk_rps   [2];

  enc_item_t   stim_items[$];
  enc_report_t pending_reports[$];

  // Bench bookkeeping
  enc_item_t   drv_item;
  enc_report_t mon_want;
  int unsigned drv_wait     = 0;
  logic        drv_armed    = 1'b0;
  int unsigned mon_wait     = 0;
  int unsigned hold_left    = 0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  logic        out_calm     = 1'b0;
  logic        gen_calm     = 1'b0;
  logic [3:0]  enc_pins     = 4'd0;
  logic [1:0]  enc_dir      = 2'b00;
  int unsigned items_sent   = 0;
  int unsigned ticks_sent   = 0;
  int unsigned resets_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned settings     = 1;

  // Tracker
  // ---------------------------------------------------------------------------
  // Count change of one encoder: first pin up when levels differ, second pin
  // the other way; both applied against the same levels
  function automatic logic [CNT_W-1:0] pin_pair_step(input logic [CNT_W-1:0] cnt,
                                                     input logic first_hit,
                                                     input logic second_hit,
                                                     input logic differ);
    logic [CNT_W-1:0] c;
    c = cnt;
    if (first_hit) c = differ ? c + 1'b1 : c - 1'b1;
    if (second_hit) c = differ ? c - 1'b1 : c + 1'b1;
    return c;
  endfunction

  function automatic void clear_track(input int m);
    trk_count[m] = '0;
    trk_last[m]  = '0;
    trk_pps[m]   = '0;
    trk_rps[m]   = '0;
  endfunction

  // Speed sample of one motor; a zero divisor counts as one
  function automatic void sample_rate(input int m);
    logic [CNT_W-1:0] delta;
    logic [CNT_W-1:0] pps;
    longint           scaled;
    longint           divisor;
    delta      = trk_count[m] - trk_last[m];
    pps        = delta * trk_sps;
    divisor    = (trk_ppr == '0) ? 64'sd1 : longint'(trk_ppr);
    scaled     = longint'(signed'(pps)) * 64'sd65536;
    trk_pps[m] = pps;
    trk_rps[m] = RPS_W'(scaled / divisor);
    trk_last[m] = trk_count[m];
  endfunction

  // Applies one accepted transaction and returns the report it must produce
  function automatic enc_report_t advance_tracker(input enc_item_t it);
    enc_report_t rep;
    logic        dl;
    logic        dr;
    longint      pps_mag;
    longint      rps_mag;
    int          m;
    dl = it.pin_levels[0] ^ it.pin_levels[1];
    dr = it.pin_levels[2] ^ it.pin_levels[3];
    case (it.cmd)
      dqes_pkg::CMD_EDGE: begin
        trk_count[0] = pin_pair_step(trk_count[0], it.edge_mask[0], it.edge_mask[1], dl);
        trk_count[1] = pin_pair_step(trk_count[1], it.edge_mask[2], it.edge_mask[3], dr);
      end
      dqes_pkg::CMD_TICK: begin
        sample_rate(0);
        sample_rate(1);
      end
      dqes_pkg::CMD_RESET: begin
        if (it.motor == dqes_pkg::MOTOR_BOTH) begin
          clear_track(0);
          clear_track(1);
        end else if (it.motor != dqes_pkg::MOTOR_NONE) begin
          clear_track((it.motor == dqes_pkg::MOTOR_RIGHT) ? 1 : 0);
        end
      end
      dqes_pkg::CMD_QUERY: ;
    endcase
    rep = '0;
    if (it.motor == dqes_pkg::MOTOR_LEFT || it.motor == dqes_pkg::MOTOR_RIGHT) begin
      m       = (it.motor == dqes_pkg::MOTOR_RIGHT) ? 1 : 0;
      pps_mag = longint'(signed'(trk_pps[m]));
      rps_mag = longint'(trk_rps[m]);
      if (pps_mag < 0) pps_mag = -pps_mag;
      if (rps_mag < 0) rps_mag = -rps_mag;
      if (pps_mag > longint'(dqes_pkg::PPS_ABS_MAX)) begin
        pps_mag = longint'(dqes_pkg::PPS_ABS_MAX);
      end
      rep.position_count   = trk_count[m];
      rep.pulse_rate       = trk_pps[m];
      rep.pulse_rate_abs   = pps_mag[CNT_W-2:0];
      rep.rev_rate_q16     = trk_rps[m];
      rep.rev_rate_abs_q16 = rps_mag[RPS_W-1:0];
    end
    return rep;
  endfunction

  function automatic void note_failure();
    fail_count++;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      note_failure();
      if (fail_count <= MAX_REPORTS) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  // Driver: presents queued transactions, waiting each one's gap first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        pending_reports.push_back(advance_tracker(drv_item));
        items_sent++;
        if (drv_item.cmd == dqes_pkg::CMD_TICK) ticks_sent++;
        if (drv_item.cmd == dqes_pkg::CMD_RESET) resets_sent++;
      end
      if (stim_items.size() > 0 && !drv_armed) begin
        drv_wait  = stim_items[0].gap;
        drv_armed = 1'b1;
      end
      if (stim_items.size() > 0 && drv_wait == 0) begin
        drv_item      = stim_items.pop_front();
        drv_armed     = 1'b0;
        in_valid      <= 1'b1;
        in_cmd        <= drv_item.cmd;
        in_motor      <= drv_item.motor;
        in_edge_mask  <= drv_item.edge_mask;
        in_pin_levels <= drv_item.pin_levels;
      end else begin
        if (drv_wait > 0) drv_wait--;
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction, then decides the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_reports.size() == 0) begin
          note_failure();
          $error("result transaction with no command outstanding");
        end else begin
          mon_want = pending_reports.pop_front();
          check_field("position_count", longint'(mon_want.position_count),
                      longint'(out_position_count));
          check_field("pulse_rate", longint'(mon_want.pulse_rate),
                      longint'(out_pulse_rate));
          check_field("pulse_rate_abs", longint'(mon_want.pulse_rate_abs),
                      longint'(out_pulse_rate_abs));
          check_field("rev_rate_q16", longint'(mon_want.rev_rate_q16),
                      longint'(out_rev_rate_q16));
          check_field("rev_rate_abs_q16", longint'(mon_want.rev_rate_abs_q16),
                      longint'(out_rev_rate_abs_q16));
        end
        // calm stretches every so often
        if (results_seen % 48 == 0) out_calm = ($urandom_range(0, 3) == 0);
        mon_wait = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (mon_wait > 0) begin
        mon_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_item(input dqes_pkg::cmd_t c, input logic [1:0] mo,
                                    input logic [3:0] mk, input logic [3:0] lv,
                                    input int unsigned gap);
    enc_item_t it;
    it.cmd        = c;
    it.motor      = mo;
    it.edge_mask  = mk;
    it.pin_levels = lv;
    it.gap        = gap;
    stim_items.push_back(it);
  endfunction

  // Directed transaction with a random gap in front
  function automatic void push_directed(input dqes_pkg::cmd_t c, input logic [1:0] mo,
                                        input logic [3:0] mk, input logic [3:0] lv);
    push_item(c, mo, mk, lv, $urandom_range(0, MAX_WAIT));
  endfunction

  // One proper quadrature step of a motor; returns the pin that toggled
  function automatic logic [3:0] quad_step(input int m);
    logic [3:0] hit;
    int         pin;
    if ($urandom_range(0, 19) == 0) enc_dir[m] = ~enc_dir[m];
    // forward toggles the first pin when the pair matches, else the second
    pin = 2 * m;
    if ((enc_pins[2*m] != enc_pins[2*m+1]) ^ enc_dir[m]) pin = 2 * m + 1;
    hit           = '0;
    hit[pin]      = 1'b1;
    enc_pins[pin] = ~enc_pins[pin];
    return hit;
  endfunction

  // Mostly clean encoder motion, plus noise edges, ticks, resets and queries
  function automatic void queue_random_item();
    int unsigned pick;
    int unsigned gap;
    logic [1:0]  mo;
    logic [3:0]  mk;
    if ($urandom_range(0, 39) == 0) gen_calm = ~gen_calm;
    gap  = gen_calm ? 0 : $urandom_range(0, MAX_WAIT);
    mo   = ($urandom_range(0, 7) < 6) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 2))
        0:       mk = quad_step(0);
        1:       mk = quad_step(1);
        default: mk = quad_step(0) | quad_step(1);
      endcase
      push_item(dqes_pkg::CMD_EDGE, mo, mk, enc_pins, gap);
    end else if (pick < 70) begin
      push_item(dqes_pkg::CMD_EDGE, mo, 4'($urandom), 4'($urandom), gap);
    end else if (pick < 85) begin
      push_item(dqes_pkg::CMD_TICK, mo, 4'($urandom), 4'($urandom), gap);
    end else if (pick < 92) begin
      push_item(dqes_pkg::CMD_RESET, 2'($urandom), 4'($urandom), 4'($urandom), gap);
    end else begin
      push_item(dqes_pkg::CMD_QUERY, mo, 4'($urandom), 4'($urandom), gap);
    end
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    if (addr == dqes_pkg::CFG_PULSES_PER_REV) trk_ppr = data;
    else trk_sps = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rates(input logic [CFG_W-1:0] ppr, input logic [CFG_W-1:0] sps);
    write_reg(dqes_pkg::CFG_PULSES_PER_REV, ppr);
    write_reg(dqes_pkg::CFG_SAMPLES_PER_S, sps);
    settings++;
  endtask

  // Returns once every queued transaction is answered and the unit has settled
  task automatic wait_idle();
    @(negedge clk);
    while (stim_items.size() != 0 || in_valid || pending_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_track(0);
    clear_track(1);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every command, both pin roles, ignored fields, motor none/both
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_LEFT,  4'b1111, 4'b1111);
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_NONE,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0001, 4'b0001);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0001, 4'b0000);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0010, 4'b0000);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0010, 4'b0010);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_RIGHT, 4'b0100, 4'b0100);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_RIGHT, 4'b1000, 4'b1100);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_BOTH,  4'b1111, 4'b1010);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_RIGHT, 4'b0101, 4'b0101);
    push_directed(dqes_pkg::CMD_TICK,  dqes_pkg::MOTOR_LEFT,  4'b1111, 4'b0110);
    push_directed(dqes_pkg::CMD_TICK,  dqes_pkg::MOTOR_RIGHT, 4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_NONE,  4'b0011, 4'b0011);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0001, 4'b0000);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0001, 4'b1100);
    push_directed(dqes_pkg::CMD_EDGE,  dqes_pkg::MOTOR_LEFT,  4'b0001, 4'b0011);
    push_directed(dqes_pkg::CMD_TICK,  dqes_pkg::MOTOR_NONE,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_TICK,  dqes_pkg::MOTOR_BOTH,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_LEFT,  4'b0000, 4'b1111);
    push_directed(dqes_pkg::CMD_RESET, dqes_pkg::MOTOR_NONE,  4'b1111, 4'b0000);
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_RIGHT, 4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_RESET, dqes_pkg::MOTOR_LEFT,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_LEFT,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_RESET, dqes_pkg::MOTOR_BOTH,  4'b0000, 4'b0000);
    push_directed(dqes_pkg::CMD_QUERY, dqes_pkg::MOTOR_RIGHT, 4'b1111, 4'b1111);
    wait_idle();

    // Random traffic under a range of rate settings, extremes included
    for (int p = 0; p < RATE_PHASES; p++) begin
      case (p)
        0:       set_rates(16'hffff, 16'hffff);
        1:       set_rates(16'd1, 16'hffff);
        2:       set_rates(16'd0, 16'($urandom_range(1, 65535)));
        3:       set_rates(16'hffff, 16'd1);
        4:       set_rates(16'($urandom), 16'($urandom));
        5:       set_rates(16'($urandom_range(1, 16)), 16'($urandom_range(1, 300)));
        default: set_rates(dqes_pkg::PPR_RESET, dqes_pkg::SPS_RESET);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
      // long receiver hold-off so the queue fills and the input stalls
      if (p == 1) hold_req = 1'b1;
      wait_idle();
    end

    if (pending_reports.size() != 0) begin
      note_failure();
      $error("%0d results never arrived", pending_reports.size());
    end
    $display("covered %0d transactions (%0d ticks, %0d resets) under %0d rate settings",
             items_sent, ticks_sent, resets_sent, settings);
    $display("%0d results checked, including a %0d-cycle receiver hold-off",
             results_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
